[hw/rtl/assert_macros.svh]
// concurrent assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/isarr_pkg.sv]
// shared types and constants of the indexed shift array
`timescale 1ns / 1ps
`default_nettype none

package isarr_pkg;

  localparam int TYPE_W = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  typedef enum logic [TYPE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]         live_count;
    logic                     is_empty;
    status_t                  status;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/isarr_mem.sv]
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module isarr_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/isarr_seq.sv]
// sequencer: request decode, checks and entry shifting through the store port
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module isarr_seq #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire logic [isarr_pkg::TYPE_W-1:0]         req_type,
  input  wire logic [isarr_pkg::POS_W-1:0]          position,
  input  wire logic signed [isarr_pkg::DATA_W-1:0]  value,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output isarr_pkg::result_t                        res,
  output logic                                      mem_we,
  output logic [$clog2(CAPACITY)-1:0]               mem_waddr,
  output logic [WORD_BITS-1:0]                      mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]               mem_raddr,
  input  wire logic [WORD_BITS-1:0]                 mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > isarr_pkg::POS_W) ? CW : isarr_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_INS_FIN,
    S_DONE
  } state_t;

  state_t                         state, state_next;
  logic [CW-1:0]                  count, count_next;
  logic [AW-1:0]                  ptr, ptr_next;
  logic [isarr_pkg::DATA_W-1:0]   data, data_next;
  isarr_pkg::status_t             status, status_next;
  isarr_pkg::op_t                 op;
  logic [PW-1:0]                  pos;
  logic [WORD_BITS-1:0]           val;

  logic                           accept;
  logic [PW-1:0]                  count_w;
  logic [AW-1:0]                  pos_idx;
  logic [AW-1:0]                  src;
  logic                           is_full;
  logic                           is_none;

  assign accept  = req_valid && req_ready;
  assign count_w = PW'(count);
  assign pos_idx = AW'(pos);
  assign src     = (op == isarr_pkg::OP_INSERT) ? (ptr - AW'(1)) : (ptr + AW'(1));
  assign is_full = (count == CW'(CAPACITY));
  assign is_none = (count == '0);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.data_out   = data;
  assign res.live_count = isarr_pkg::CNT_W'(count);
  assign res.is_empty   = is_none;
  assign res.status     = status;

  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    data_next   = data;
    status_next = status;
    mem_we      = 1'b0;
    mem_waddr   = ptr;
    mem_wdata   = mem_rdata;
    mem_raddr   = src;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        data_next   = '0;
        status_next = isarr_pkg::ST_OK;
        state_next  = S_DONE;
        case (op)
          isarr_pkg::OP_PUSH: begin
            if (is_full) begin
              status_next = isarr_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = AW'(count);
              mem_wdata  = val;
              count_next = count + CW'(1);
            end
          end
          isarr_pkg::OP_POP: begin
            if (is_none) begin
              status_next = isarr_pkg::ST_EMPTY;
            end else begin
              mem_raddr  = AW'(count - CW'(1));
              count_next = count - CW'(1);
              state_next = S_RD_WAIT;
            end
          end
          isarr_pkg::OP_INSERT: begin
            if (is_full) begin
              status_next = isarr_pkg::ST_FULL;
            end else if (pos > count_w) begin
              status_next = isarr_pkg::ST_RANGE;
            end else if (pos == count_w) begin
              mem_we     = 1'b1;
              mem_waddr  = pos_idx;
              mem_wdata  = val;
              count_next = count + CW'(1);
            end else begin
              ptr_next   = AW'(count);
              state_next = S_SH_RD;
            end
          end
          isarr_pkg::OP_REMOVE, isarr_pkg::OP_READ: begin
            if (is_none) begin
              status_next = isarr_pkg::ST_EMPTY;
            end else if (pos >= count_w) begin
              status_next = isarr_pkg::ST_RANGE;
            end else begin
              mem_raddr  = pos_idx;
              ptr_next   = pos_idx;
              state_next = S_RD_WAIT;
            end
          end
          isarr_pkg::OP_WRITE: begin
            if (is_none) begin
              status_next = isarr_pkg::ST_EMPTY;
            end else if (pos >= count_w) begin
              status_next = isarr_pkg::ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pos_idx;
              mem_wdata = val;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD_WAIT: begin
        data_next  = isarr_pkg::DATA_W'(signed'(mem_rdata));
        state_next = S_DONE;
        if (op == isarr_pkg::OP_REMOVE) begin
          if (CW'(ptr) + CW'(1) == count) begin
            count_next = count - CW'(1);
          end else begin
            state_next = S_SH_RD;
          end
        end
      end
      S_SH_RD: begin
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        ptr_next  = src;
        if (op == isarr_pkg::OP_INSERT) begin
          state_next = (src == pos_idx) ? S_INS_FIN : S_SH_RD;
        end else if (CW'(src) + CW'(1) == count) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_INS_FIN: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_idx;
        mem_wdata  = val;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    ptr    <= ptr_next;
    data   <= data_next;
    status <= status_next;
    if (accept) begin
      op  <= isarr_pkg::op_t'(req_type);
      pos <= PW'(position);
      val <= WORD_BITS'(value);
    end
  end

  `ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `ASSERT_IMPL(a_write_state, mem_we, state == S_EVAL || state == S_SH_WR || state == S_INS_FIN)
  `ASSERT_NEXT(a_shift_pair, state == S_SH_RD, state == S_SH_WR)
  `ASSERT_NEXT(a_accept_eval, accept, state == S_EVAL)

endmodule

`default_nettype wire

[hw/rtl/indexed_shift_array.sv]
// top level of the indexed shift array: sequencer, entry store, result register
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of up to CAPACITY signed words held in a single-port-pair
// memory (one write, one registered read per cycle). Requests are taken one at
// a time. Push, write, insert at the end of the list, the unused request codes
// and every failed request end right after evaluation; pop and read also wait
// for the registered read. Insert at index i below the live count n moves the
// entries i..n-1 up one place, then writes the new word at i; remove at i moves
// the entries above i down one place, each moved entry costing one memory read
// and one memory write through the shared store port. A finished result sits in
// an output register, so a new request can be taken while it waits for rsp_ready.

module indexed_shift_array #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire logic [isarr_pkg::TYPE_W-1:0]         req_type,
  input  wire logic [isarr_pkg::POS_W-1:0]          position,
  input  wire logic signed [isarr_pkg::DATA_W-1:0]  value,
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_ready,
  output logic signed [isarr_pkg::DATA_W-1:0]       data_out,
  output logic [isarr_pkg::CNT_W-1:0]               live_count,
  output logic                                      is_empty,
  output logic [1:0]                                status
);

  localparam int AW = $clog2(CAPACITY);

  logic                  res_valid;
  logic                  res_ready;
  isarr_pkg::result_t    res;
  isarr_pkg::result_t    rsp;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;

  isarr_seq #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .position  (position),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  isarr_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output beat register
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  assign data_out   = rsp.data_out;
  assign live_count = rsp.live_count;
  assign is_empty   = rsp.is_empty;
  assign status     = rsp.status;

endmodule

`default_nettype wire
